FILE: rtl/pte_pkg.sv
// shared types, constants and codes for the process table engine
package pte_pkg;

	localparam int TABLE_SLOTS  = 16;
	localparam int SIGNAL_COUNT = 16;
	localparam int SLOT_W       = $clog2(TABLE_SLOTS);
	localparam int TRY_W        = $clog2(TABLE_SLOTS + 2);
	localparam int CNT_W        = $clog2(TABLE_SLOTS + 1);
	localparam int CFG_IDX_W    = 1;
	localparam int CFG_DATA_W   = 16;
	localparam logic [14:0] PID_WRAP_LIMIT = 15'd32000;

	typedef enum logic [3:0] {
		REQ_ALLOC      = 4'd0,
		REQ_SET_STATUS = 4'd1,
		REQ_SLEEP      = 4'd2,
		REQ_WAKEUP     = 4'd3,
		REQ_SIGNAL     = 4'd4,
		REQ_SCHEDULE   = 4'd5,
		REQ_SET_IGN    = 4'd6,
		REQ_READ       = 4'd7,
		REQ_CLEAR_SIG  = 4'd8
	} req_t;

	typedef enum logic [2:0] {
		ST_EMPTY   = 3'd0,
		ST_RUNNING = 3'd1,
		ST_READY   = 3'd2,
		ST_SLEEP   = 3'd3,
		ST_PAUSE   = 3'd4,
		ST_FORKING = 3'd5,
		ST_WAIT    = 3'd6
	} proc_st_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_FULL      = 3'd1,
		ERR_NOT_RUN   = 3'd2,
		ERR_RUNNING   = 3'd3,
		ERR_NO_READY  = 3'd4
	} err_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_TABLE_BASE   = 1'd0,
		CFG_ENTRY_STRIDE = 1'd1
	} cfg_reg_t;

	typedef enum logic [3:0] {
		OP_NONE, OP_FREE, OP_PID_ADV, OP_PID_CHK, OP_ALLOC,
		OP_WAKE, OP_SIG, OP_SCHED, OP_SINGLE
	} op_t;

	typedef enum logic [3:0] {
		FSM_IDLE, FSM_FREE, FSM_PID_ADV, FSM_PID_CHK, FSM_ALLOC,
		FSM_WAKE, FSM_SIG, FSM_SCHED, FSM_SINGLE, FSM_OUT
	} fsm_t;

	typedef struct packed {
		logic latch;
		op_t  op;
		logic idx_inc;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic pid_hit;
		logic tries_done;
		logic last_idx;
		logic sched_hit;
		logic sched_last;
		logic out_free;
	} sts_t;

	typedef struct packed {
		logic        ok;
		logic [2:0]  error_code;
		logic [3:0]  slot;
		logic [14:0] pid;
		logic [2:0]  status;
		logic [15:0] pending;
		logic [15:0] wait_tag;
	} res_t;

endpackage

FILE: rtl/pte_if.sv
// request and result channel interfaces
interface pte_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  req_type;
	logic [3:0]  slot;
	logic        broadcast;
	logic [2:0]  new_status;
	logic [15:0] event_req;
	logic [3:0]  sig;
	logic [15:0] mask_value;

	modport source (output valid, req_type, slot, broadcast, new_status, event_req, sig,
		mask_value, input ready);
	modport sink (input valid, req_type, slot, broadcast, new_status, event_req, sig,
		mask_value, output ready);
endinterface

interface pte_res_if;
	logic        valid;
	logic        ready;
	logic        ok;
	logic [2:0]  error_code;
	logic [3:0]  result_slot;
	logic [14:0] result_pid;
	logic [2:0]  result_status;
	logic [15:0] result_pending;
	logic [15:0] result_wait;
	logic [4:0]  woken_count;

	modport source (output valid, ok, error_code, result_slot, result_pid, result_status,
		result_pending, result_wait, woken_count, input ready);
	modport sink (input valid, ok, error_code, result_slot, result_pid, result_status,
		result_pending, result_wait, woken_count, output ready);
endinterface

FILE: rtl/process_table_engine_unit.sv
// Process table engine: a 16-slot table of status, pid, wait tag, pending and
// ignored signal masks, run one request at a time. A single-slot request is
// latched, applied to its slot, then loaded into the result register. Wakeup
// and broadcast signal sweep all slots through one entry port, one slot a
// cycle. Schedule walks round-robin from the slot after the pointer and stops
// at the first ready or running slot. Alloc first scans for the first empty
// slot, then for each pid candidate steps the counter and sweeps the table
// for a clash. A finished result waits in an output register, so the next
// request is taken while it is still held.
module process_table_engine_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	pte_req_if.sink                        req_ch,
	pte_res_if.source                      res_ch,
	input  logic                           cfg_we,
	input  logic [pte_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pte_pkg::CFG_DATA_W-1:0] cfg_wdata
);

	pte_pkg::cmd_t cmd;
	pte_pkg::sts_t sts;
	pte_pkg::res_t res;

	pte_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req_ch.valid),
		.req_type  (req_ch.req_type),
		.broadcast (req_ch.broadcast),
		.sts       (sts),
		.in_ready  (req_ch.ready),
		.cmd       (cmd)
	);

	pte_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.req_type   (req_ch.req_type),
		.slot       (req_ch.slot),
		.broadcast  (req_ch.broadcast),
		.new_status (req_ch.new_status),
		.event_req  (req_ch.event_req),
		.sig        (req_ch.sig),
		.mask_value (req_ch.mask_value),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.out_valid  (res_ch.valid),
		.out_ready  (res_ch.ready),
		.out_res    (res),
		.out_woken  (res_ch.woken_count)
	);

	assign res_ch.ok             = res.ok;
	assign res_ch.error_code     = res.error_code;
	assign res_ch.result_slot    = res.slot;
	assign res_ch.result_pid     = res.pid;
	assign res_ch.result_status  = res.status;
	assign res_ch.result_pending = res.pending;
	assign res_ch.result_wait    = res.wait_tag;

endmodule

FILE: rtl/pte_ctrl.sv
// request sequencer: walks the table scans and issues datapath commands
module pte_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [3:0]      req_type,
	input  logic            broadcast,
	input  pte_pkg::sts_t   sts,
	output logic            in_ready,
	output pte_pkg::cmd_t   cmd
);

	pte_pkg::fsm_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pte_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		in_ready     = 1'b0;
		cmd.latch    = 1'b0;
		cmd.op       = pte_pkg::OP_NONE;
		cmd.idx_inc  = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			pte_pkg::FSM_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch = 1'b1;
					case (pte_pkg::req_t'(req_type))
						pte_pkg::REQ_ALLOC:    state_d = pte_pkg::FSM_FREE;
						pte_pkg::REQ_WAKEUP:   state_d = pte_pkg::FSM_WAKE;
						pte_pkg::REQ_SCHEDULE: state_d = pte_pkg::FSM_SCHED;
						pte_pkg::REQ_SIGNAL:
							state_d = broadcast ? pte_pkg::FSM_SIG : pte_pkg::FSM_SINGLE;
						default:               state_d = pte_pkg::FSM_SINGLE;
					endcase
				end
			end
			pte_pkg::FSM_FREE: begin
				cmd.op = pte_pkg::OP_FREE;
				if (sts.empty) begin
					state_d = pte_pkg::FSM_PID_ADV;
				end else if (sts.last_idx) begin
					state_d = pte_pkg::FSM_OUT;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			pte_pkg::FSM_PID_ADV: begin
				cmd.op  = pte_pkg::OP_PID_ADV;
				state_d = pte_pkg::FSM_PID_CHK;
			end
			pte_pkg::FSM_PID_CHK: begin
				cmd.op = pte_pkg::OP_PID_CHK;
				if (sts.pid_hit) begin
					state_d = sts.tries_done ? pte_pkg::FSM_ALLOC : pte_pkg::FSM_PID_ADV;
				end else if (sts.last_idx) begin
					state_d = pte_pkg::FSM_ALLOC;
				end else begin
					cmd.idx_inc = 1'b1;
				end
			end
			pte_pkg::FSM_ALLOC: begin
				cmd.op  = pte_pkg::OP_ALLOC;
				state_d = pte_pkg::FSM_OUT;
			end
			pte_pkg::FSM_WAKE, pte_pkg::FSM_SIG: begin
				cmd.op      = (state_q == pte_pkg::FSM_WAKE) ? pte_pkg::OP_WAKE : pte_pkg::OP_SIG;
				cmd.idx_inc = 1'b1;
				if (sts.last_idx) state_d = pte_pkg::FSM_OUT;
			end
			pte_pkg::FSM_SCHED: begin
				cmd.op      = pte_pkg::OP_SCHED;
				cmd.idx_inc = 1'b1;
				if (sts.sched_hit || sts.sched_last) state_d = pte_pkg::FSM_OUT;
			end
			pte_pkg::FSM_SINGLE: begin
				cmd.op  = pte_pkg::OP_SINGLE;
				state_d = pte_pkg::FSM_OUT;
			end
			pte_pkg::FSM_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = pte_pkg::FSM_IDLE;
				end
			end
			default: state_d = pte_pkg::FSM_IDLE;
		endcase
	end

endmodule

FILE: rtl/pte_dp.sv
// process table storage, per-entry update logic and result register
module pte_dp (
	input  logic                              clk,
	input  logic                              arst_n,
	input  pte_pkg::cmd_t                     cmd,
	output pte_pkg::sts_t                     sts,
	input  logic [3:0]                        req_type,
	input  logic [3:0]                        slot,
	input  logic                              broadcast,
	input  logic [2:0]                        new_status,
	input  logic [15:0]                       event_req,
	input  logic [3:0]                        sig,
	input  logic [15:0]                       mask_value,
	input  logic                              cfg_we,
	input  logic [pte_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pte_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output logic                              out_valid,
	input  logic                              out_ready,
	output pte_pkg::res_t                     out_res,
	output logic [4:0]                        out_woken
);

	localparam int N = pte_pkg::TABLE_SLOTS;
	localparam int SW = pte_pkg::SLOT_W;
	localparam logic [pte_pkg::CNT_W-1:0] CNT_ONE = 1;

	logic [2:0]  status_q [N];
	logic [14:0] pid_q    [N];
	logic [15:0] wait_q   [N];
	logic [15:0] pend_q   [N];
	logic [15:0] ign_q    [N];

	logic [14:0] next_pid_q;
	logic [SW-1:0] ptr_q, idx_q, free_q;
	logic [pte_pkg::TRY_W-1:0] try_q;
	logic [pte_pkg::CNT_W-1:0] cnt_q;
	logic [15:0] base_q;
	logic [7:0]  stride_q;

	logic [3:0]  req_l;
	logic [3:0]  slot_l;
	logic        bcast_l;
	logic [2:0]  nst_l;
	logic [15:0] ev_l;
	logic [3:0]  sig_l;
	logic [15:0] mval_l;

	pte_pkg::res_t res_q;
	logic          out_valid_q;
	pte_pkg::res_t out_q;
	logic [4:0]    out_woken_q;

	logic [SW-1:0] addr, slot_ix, ptr_nxt, idx_nxt;
	logic [2:0]  e_st;
	logic [14:0] e_pid;
	logic [15:0] e_wait, e_pend, e_ign;
	logic        slot_ok, sig_ok, post_eff, post_wake;
	logic [15:0] bit_m, own_tag;
	logic [2:0]  sleep_st;

	assign slot_ix = SW'(slot_l);
	assign addr    = (cmd.op == pte_pkg::OP_SINGLE) ? slot_ix : idx_q;
	assign ptr_nxt = (32'(ptr_q) == N - 1) ? '0 : ptr_q + 1'b1;
	assign idx_nxt = (32'(idx_q) == N - 1) ? '0 : idx_q + 1'b1;

	assign e_st   = status_q[addr];
	assign e_pid  = pid_q[addr];
	assign e_wait = wait_q[addr];
	assign e_pend = pend_q[addr];
	assign e_ign  = ign_q[addr];

	assign slot_ok = 32'(slot_l) < N;
	assign sig_ok  = (sig_l != 4'd0) && (32'(sig_l) < pte_pkg::SIGNAL_COUNT);
	assign bit_m   = sig_ok ? (16'd1 << (sig_l - 4'd1)) : 16'd0;

	// a signal lands unless the slot is empty or masks it
	assign post_eff  = (e_st != pte_pkg::ST_EMPTY) && ((e_ign & bit_m) == 16'd0);
	assign post_wake = post_eff && (e_st == pte_pkg::ST_PAUSE || e_st == pte_pkg::ST_WAIT ||
		e_st == pte_pkg::ST_SLEEP);

	assign own_tag  = base_q + 16'(addr) * 16'(stride_q);
	assign sleep_st = (ev_l == 16'd0) ? pte_pkg::ST_PAUSE :
		(ev_l == own_tag) ? pte_pkg::ST_WAIT : pte_pkg::ST_SLEEP;

	assign sts.empty      = (e_st == pte_pkg::ST_EMPTY);
	assign sts.pid_hit    = (e_st != pte_pkg::ST_EMPTY) && (e_pid == next_pid_q);
	assign sts.tries_done = (32'(try_q) == N + 1);
	assign sts.last_idx   = (32'(idx_q) == N - 1);
	assign sts.sched_hit  = (e_st == pte_pkg::ST_RUNNING) || (e_st == pte_pkg::ST_READY);
	assign sts.sched_last = (32'(try_q) == N - 1);
	assign sts.out_free   = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N; i++) begin
				status_q[i] <= pte_pkg::ST_EMPTY;
				pid_q[i]    <= '0;
				wait_q[i]   <= '0;
				pend_q[i]   <= '0;
				ign_q[i]    <= '0;
			end
			next_pid_q  <= '0;
			ptr_q       <= '0;
			idx_q       <= '0;
			free_q      <= '0;
			try_q       <= '0;
			cnt_q       <= '0;
			base_q      <= '0;
			stride_q    <= 8'd32;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (pte_pkg::cfg_reg_t'(cfg_index))
					pte_pkg::CFG_TABLE_BASE:   base_q   <= cfg_wdata[15:0];
					pte_pkg::CFG_ENTRY_STRIDE: stride_q <= cfg_wdata[7:0];
					default: ;
				endcase
			end
			if (cmd.latch) begin
				req_l   <= req_type;
				slot_l  <= slot;
				bcast_l <= broadcast;
				nst_l   <= new_status;
				ev_l    <= event_req;
				sig_l   <= sig;
				mval_l  <= mask_value;
				res_q   <= '0;
				cnt_q   <= '0;
				try_q   <= '0;
				idx_q   <= (pte_pkg::req_t'(req_type) == pte_pkg::REQ_SCHEDULE) ? ptr_nxt : '0;
			end
			if (cmd.idx_inc) idx_q <= idx_nxt;
			case (cmd.op)
				pte_pkg::OP_FREE: begin
					if (sts.empty) free_q <= idx_q;
					else if (sts.last_idx) res_q.error_code <= pte_pkg::ERR_FULL;
				end
				pte_pkg::OP_PID_ADV: begin
					next_pid_q <= (next_pid_q > pte_pkg::PID_WRAP_LIMIT) ? 15'd1 :
						next_pid_q + 15'd1;
					try_q <= try_q + 1'b1;
					idx_q <= '0;
				end
				pte_pkg::OP_PID_CHK: ;
				pte_pkg::OP_ALLOC: begin
					status_q[free_q] <= pte_pkg::ST_FORKING;
					pid_q[free_q]    <= next_pid_q;
					wait_q[free_q]   <= '0;
					pend_q[free_q]   <= '0;
					ign_q[free_q]    <= '0;
					res_q.ok         <= 1'b1;
					res_q.slot       <= 4'(free_q);
					res_q.pid        <= next_pid_q;
					res_q.status     <= pte_pkg::ST_FORKING;
				end
				pte_pkg::OP_WAKE: begin
					res_q.ok <= 1'b1;
					if (e_st > pte_pkg::ST_RUNNING && e_wait == ev_l) begin
						status_q[addr] <= pte_pkg::ST_READY;
						wait_q[addr]   <= '0;
						cnt_q          <= cnt_q + 1'b1;
					end
				end
				pte_pkg::OP_SIG: begin
					// a bad signal number leaves the table alone and returns a result with ok low
					if (sig_ok) begin
						res_q.ok <= 1'b1;
						if (post_eff) begin
							if (post_wake) status_q[addr] <= pte_pkg::ST_READY;
							wait_q[addr] <= '0;
							pend_q[addr] <= e_pend | bit_m;
						end
						if (post_wake) cnt_q <= cnt_q + 1'b1;
					end
				end
				pte_pkg::OP_SCHED: begin
					try_q <= try_q + 1'b1;
					if (sts.sched_hit) begin
						ptr_q        <= idx_q;
						res_q.slot   <= 4'(idx_q);
						res_q.status <= e_st;
						if (e_st == pte_pkg::ST_RUNNING) res_q.error_code <= pte_pkg::ERR_RUNNING;
						else res_q.ok <= 1'b1;
					end else if (sts.sched_last) begin
						res_q.error_code <= pte_pkg::ERR_NO_READY;
					end
				end
				pte_pkg::OP_SINGLE: begin
					case (pte_pkg::req_t'(req_l))
						pte_pkg::REQ_SET_STATUS: begin
							if (slot_ok && nst_l <= pte_pkg::ST_WAIT) begin
								status_q[addr] <= nst_l;
								res_q.ok       <= 1'b1;
								res_q.slot     <= slot_l;
								res_q.status   <= nst_l;
							end
						end
						pte_pkg::REQ_SLEEP: begin
							if (slot_ok) begin
								res_q.slot <= slot_l;
								if (e_st != pte_pkg::ST_RUNNING) begin
									res_q.error_code <= pte_pkg::ERR_NOT_RUN;
									res_q.status     <= e_st;
								end else begin
									status_q[addr] <= sleep_st;
									wait_q[addr]   <= ev_l;
									res_q.ok       <= 1'b1;
									res_q.status   <= sleep_st;
								end
							end
						end
						pte_pkg::REQ_SIGNAL: begin
							if (sig_ok && !bcast_l && slot_ok) begin
								if (post_eff) begin
									if (post_wake) status_q[addr] <= pte_pkg::ST_READY;
									wait_q[addr] <= '0;
									pend_q[addr] <= e_pend | bit_m;
								end
								res_q.ok     <= 1'b1;
								res_q.slot   <= slot_l;
								res_q.status <= post_wake ? pte_pkg::ST_READY : e_st;
								cnt_q        <= post_wake ? CNT_ONE : '0;
							end
						end
						pte_pkg::REQ_SET_IGN: begin
							if (slot_ok) begin
								ign_q[addr] <= mval_l;
								res_q.ok    <= 1'b1;
								res_q.slot  <= slot_l;
							end
						end
						pte_pkg::REQ_READ: begin
							if (slot_ok) begin
								res_q.ok       <= 1'b1;
								res_q.slot     <= slot_l;
								res_q.pid      <= e_pid;
								res_q.status   <= e_st;
								res_q.pending  <= e_pend;
								res_q.wait_tag <= e_wait;
							end
						end
						pte_pkg::REQ_CLEAR_SIG: begin
							if (slot_ok && sig_ok) begin
								pend_q[addr] <= e_pend & ~bit_m;
								res_q.ok     <= 1'b1;
								res_q.slot   <= slot_l;
							end
						end
						default: ;
					endcase
				end
				default: ;
			endcase
			// result register frees the engine while the consumer stalls
			if (cmd.load_out) begin
				out_q       <= res_q;
				out_woken_q <= 5'(cnt_q);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;
	assign out_woken = out_woken_q;

	a_alloc_forking: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == pte_pkg::OP_ALLOC) |=> (status_q[$past(free_q)] == pte_pkg::ST_FORKING))
		else $error("allocated slot not marked forking");
	a_pid_range: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == pte_pkg::OP_PID_ADV) |=> (next_pid_q >= 15'd1 && next_pid_q <= 15'd32001))
		else $error("pid advanced out of range");
	a_woken_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> (32'(out_woken_q) <= N))
		else $error("woken count above table size");

endmodule

FILE: sim/process_table_engine_unit_test.sv
// testbench for the process table engine: directed and random requests checked against a predictor
`timescale 1ns / 1ps
module process_table_engine_unit_test;

	typedef struct {
		logic        ok;
		logic [2:0]  error_code;
		logic [3:0]  slot;
		logic [14:0] pid;
		logic [2:0]  status;
		logic [15:0] pending;
		logic [15:0] wait_tag;
		logic [4:0]  woken;
	} outcome_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [pte_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [pte_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

	pte_req_if req_ch();
	pte_res_if res_ch();

	process_table_engine_unit uut (
		.clk(clk), .arst_n(arst_n), .req_ch(req_ch), .res_ch(res_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// predictor state
	logic [2:0]  tbl_status [pte_pkg::TABLE_SLOTS];
	logic [14:0] tbl_pid [pte_pkg::TABLE_SLOTS];
	logic [15:0] tbl_wait [pte_pkg::TABLE_SLOTS];
	logic [15:0] tbl_pend [pte_pkg::TABLE_SLOTS];
	logic [15:0] tbl_ign [pte_pkg::TABLE_SLOTS];
	logic [14:0] pid_counter;
	logic [3:0]  rr_pointer;
	logic [15:0] cfg_base;
	logic [7:0]  cfg_stride;

	outcome_t expected_q[$];
	int errors = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int results_seen = 0;
	int requests_sent = 0;

	function automatic bit pid_taken(logic [14:0] p);
		for (int i = 0; i < pte_pkg::TABLE_SLOTS; i++)
			if (tbl_status[i] != pte_pkg::ST_EMPTY && tbl_pid[i] == p) return 1;
		return 0;
	endfunction

	function automatic logic [4:0] deliver_signal(int s, logic [15:0] b);
		logic [2:0] st;
		logic [4:0] woke;
		st = tbl_status[s];
		woke = 0;
		if (st == pte_pkg::ST_EMPTY || (tbl_ign[s] & b) != 0) return 0;
		if (st == pte_pkg::ST_PAUSE || st == pte_pkg::ST_WAIT || st == pte_pkg::ST_SLEEP) begin
			tbl_status[s] = pte_pkg::ST_READY;
			woke = 1;
		end
		tbl_wait[s] = 0;
		tbl_pend[s] |= b;
		return woke;
	endfunction

	function automatic outcome_t predict_request(logic [3:0] rq, logic [3:0] s, logic bc,
			logic [2:0] nst, logic [15:0] ev, logic [3:0] sg, logic [15:0] mv);
		outcome_t o;
		bit sig_ok;
		logic [15:0] b;
		logic [15:0] own;
		int free_slot;
		int p;
		o = '{default: 0};
		sig_ok = sg >= 1 && sg < pte_pkg::SIGNAL_COUNT;
		b = sig_ok ? 16'(1 << (sg - 1)) : 16'd0;
		case (rq)
			pte_pkg::REQ_ALLOC: begin
				free_slot = pte_pkg::TABLE_SLOTS;
				for (int i = 0; i < pte_pkg::TABLE_SLOTS; i++)
					if (tbl_status[i] == pte_pkg::ST_EMPTY) begin
						free_slot = i;
						break;
					end
				if (free_slot == pte_pkg::TABLE_SLOTS) o.error_code = pte_pkg::ERR_FULL;
				else begin
					for (int t = 0; t <= pte_pkg::TABLE_SLOTS; t++) begin
						if (pid_counter > pte_pkg::PID_WRAP_LIMIT) pid_counter = 15'd1;
						else pid_counter = pid_counter + 15'd1;
						if (!pid_taken(pid_counter)) break;
					end
					tbl_pid[free_slot] = pid_counter;
					tbl_status[free_slot] = pte_pkg::ST_FORKING;
					tbl_wait[free_slot] = 0;
					tbl_pend[free_slot] = 0;
					tbl_ign[free_slot] = 0;
					o.ok = 1; o.slot = 4'(free_slot); o.pid = pid_counter;
					o.status = pte_pkg::ST_FORKING;
				end
			end
			pte_pkg::REQ_SET_STATUS: if (nst <= pte_pkg::ST_WAIT) begin
				tbl_status[s] = nst;
				o.ok = 1; o.slot = s; o.status = nst;
			end
			pte_pkg::REQ_SLEEP: begin
				o.slot = s;
				if (tbl_status[s] != pte_pkg::ST_RUNNING) begin
					o.error_code = pte_pkg::ERR_NOT_RUN;
					o.status = tbl_status[s];
				end else begin
					own = cfg_base + 16'(s) * 16'(cfg_stride);
					if (ev == 0) tbl_status[s] = pte_pkg::ST_PAUSE;
					else if (ev == own) tbl_status[s] = pte_pkg::ST_WAIT;
					else tbl_status[s] = pte_pkg::ST_SLEEP;
					tbl_wait[s] = ev;
					o.ok = 1; o.status = tbl_status[s];
				end
			end
			pte_pkg::REQ_WAKEUP: begin
				for (int i = 0; i < pte_pkg::TABLE_SLOTS; i++)
					if (tbl_status[i] > pte_pkg::ST_RUNNING && tbl_wait[i] == ev) begin
						tbl_status[i] = pte_pkg::ST_READY;
						tbl_wait[i] = 0;
						o.woken++;
					end
				o.ok = 1;
			end
			pte_pkg::REQ_SIGNAL: if (sig_ok) begin
				if (bc) begin
					for (int i = 0; i < pte_pkg::TABLE_SLOTS; i++)
						o.woken += deliver_signal(i, b);
				end else begin
					o.woken = deliver_signal(int'(s), b);
					o.slot = s; o.status = tbl_status[s];
				end
				o.ok = 1;
			end
			pte_pkg::REQ_SCHEDULE: begin
				p = int'(rr_pointer);
				for (int n = 0; n < pte_pkg::TABLE_SLOTS; n++) begin
					p = (p + 1) % pte_pkg::TABLE_SLOTS;
					if (tbl_status[p] == pte_pkg::ST_RUNNING) begin
						rr_pointer = 4'(p); o.error_code = pte_pkg::ERR_RUNNING;
						o.slot = 4'(p); o.status = pte_pkg::ST_RUNNING;
						break;
					end
					if (tbl_status[p] == pte_pkg::ST_READY) begin
						rr_pointer = 4'(p); o.ok = 1; o.slot = 4'(p);
						o.status = pte_pkg::ST_READY;
						break;
					end
				end
				if (!o.ok && o.error_code == pte_pkg::ERR_NONE)
					o.error_code = pte_pkg::ERR_NO_READY;
			end
			pte_pkg::REQ_SET_IGN: begin
				tbl_ign[s] = mv;
				o.ok = 1; o.slot = s;
			end
			pte_pkg::REQ_READ: begin
				o.ok = 1; o.slot = s; o.pid = tbl_pid[s]; o.status = tbl_status[s];
				o.pending = tbl_pend[s]; o.wait_tag = tbl_wait[s];
			end
			pte_pkg::REQ_CLEAR_SIG: if (sig_ok) begin
				tbl_pend[s] &= ~b;
				o.ok = 1; o.slot = s;
			end
			default: ;
		endcase
		return o;
	endfunction

	initial begin
		req_ch.valid = 0;
		req_ch.req_type = 0;
		req_ch.slot = 0;
		req_ch.broadcast = 0;
		req_ch.new_status = 0;
		req_ch.event_req = 0;
		req_ch.sig = 0;
		req_ch.mask_value = 0;
	end

	// cycle limit and receiver stalls
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 1500000) begin
			$display("timeout at %0t", $time);
			$display("DONE: errors detected");
			$finish;
		end
		res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// result checker
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			results_seen++;
			if (expected_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result", $time);
			end else begin
				e = expected_q.pop_front();
				if (res_ch.ok !== e.ok || res_ch.error_code !== e.error_code ||
						res_ch.result_slot !== e.slot || res_ch.result_pid !== e.pid ||
						res_ch.result_status !== e.status ||
						res_ch.result_pending !== e.pending ||
						res_ch.result_wait !== e.wait_tag || res_ch.woken_count !== e.woken) begin
					errors++;
					$display("%0t: mismatch expected ok=%0d err=%0d slot=%0d pid=%0d st=%0d",
						$time, e.ok, e.error_code, e.slot, e.pid, e.status);
					$display("    expected pend=%h wait=%h woken=%0d",
						e.pending, e.wait_tag, e.woken);
					$display("%0t: actual ok=%0d err=%0d slot=%0d pid=%0d st=%0d",
						$time, res_ch.ok, res_ch.error_code, res_ch.result_slot,
						res_ch.result_pid, res_ch.result_status);
					$display("    actual pend=%h wait=%h woken=%0d",
						res_ch.result_pending, res_ch.result_wait, res_ch.woken_count);
				end
			end
		end
	end

	task automatic send_request(logic [3:0] rq, logic [3:0] s, logic bc, logic [2:0] nst,
			logic [15:0] ev, logic [3:0] sg, logic [15:0] mv);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 0;
			@(posedge clk);
		end
		req_ch.valid <= 1;
		req_ch.req_type <= rq;
		req_ch.slot <= s;
		req_ch.broadcast <= bc;
		req_ch.new_status <= nst;
		req_ch.event_req <= ev;
		req_ch.sig <= sg;
		req_ch.mask_value <= mv;
		do @(posedge clk); while (!req_ch.ready);
		expected_q.push_back(predict_request(rq, s, bc, nst, ev, sg, mv));
		requests_sent++;
	endtask

	task automatic drain();
		req_ch.valid <= 0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_register(pte_pkg::cfg_reg_t idx, logic [15:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 0;
		if (idx == pte_pkg::CFG_TABLE_BASE) cfg_base = val;
		else cfg_stride = val[7:0];
		@(posedge clk);
	endtask

	task automatic test_directed();
		send_request(pte_pkg::REQ_SCHEDULE, 0, 0, 0, 0, 1, 0);
		send_request(pte_pkg::REQ_READ, 15, 0, 0, 0, 0, 0);
		for (int i = 0; i < pte_pkg::TABLE_SLOTS; i++)
			send_request(pte_pkg::REQ_ALLOC, 0, 0, 0, 0, 0, 0);
		send_request(pte_pkg::REQ_ALLOC, 0, 0, 0, 0, 0, 0);
		send_request(pte_pkg::REQ_SET_STATUS, 1, 0, 7, 0, 0, 0);
		send_request(pte_pkg::REQ_SET_STATUS, 1, 0, pte_pkg::ST_RUNNING, 0, 0, 0);
		send_request(pte_pkg::REQ_SLEEP, 2, 0, 0, 0, 0, 0);
		send_request(pte_pkg::REQ_SLEEP, 1, 0, 0, 16'h0000, 0, 0);
		send_request(pte_pkg::REQ_SIGNAL, 1, 0, 0, 0, 0, 0);
		send_request(pte_pkg::REQ_SIGNAL, 1, 0, 0, 0, 15, 0);
		send_request(pte_pkg::REQ_CLEAR_SIG, 1, 0, 0, 0, 15, 0);
		send_request(4'd9, 0, 0, 0, 0, 0, 0);
		send_request(4'd15, 15, 1, 7, 16'hFFFF, 15, 16'hFFFF);
	endtask

	task automatic test_pid_wrap();
		// free slot 0 and reallocate it repeatedly so the pid counter keeps advancing
		for (int n = 0; n < 20; n++) begin
			send_request(pte_pkg::REQ_SET_STATUS, 0, 0, pte_pkg::ST_EMPTY, 0, 0, 0);
			send_request(pte_pkg::REQ_ALLOC, 0, 0, 0, 0, 0, 0);
		end
		drain();
	endtask

	task automatic random_item();
		logic [3:0] rq;
		logic [3:0] s;
		logic [15:0] ev;
		int k;
		s = 4'($urandom_range(15));
		k = $urandom_range(99);
		if (k < 12) rq = pte_pkg::REQ_ALLOC;
		else if (k < 25) rq = pte_pkg::REQ_SET_STATUS;
		else if (k < 40) rq = pte_pkg::REQ_SLEEP;
		else if (k < 50) rq = pte_pkg::REQ_WAKEUP;
		else if (k < 62) rq = pte_pkg::REQ_SIGNAL;
		else if (k < 74) rq = pte_pkg::REQ_SCHEDULE;
		else if (k < 80) rq = pte_pkg::REQ_SET_IGN;
		else if (k < 90) rq = pte_pkg::REQ_READ;
		else if (k < 97) rq = pte_pkg::REQ_CLEAR_SIG;
		else rq = 4'($urandom_range(15));
		case ($urandom_range(3))
			0: ev = 0;
			1: ev = cfg_base + 16'(s) * 16'(cfg_stride);
			2: ev = 16'($urandom_range(3));
			default: ev = 16'($urandom);
		endcase
		send_request(rq, s, 1'($urandom_range(1)),
			($urandom_range(3) == 0) ? 3'($urandom_range(7)) : pte_pkg::ST_RUNNING, ev,
			4'($urandom_range(15)), ($urandom_range(1) ? 16'($urandom) : 16'd0));
	endtask

	task automatic test_random(int count, int s_idle, int r_idle);
		send_idle_pct = s_idle;
		recv_idle_pct = r_idle;
		for (int i = 0; i < count; i++) random_item();
	endtask

	initial begin
		for (int i = 0; i < pte_pkg::TABLE_SLOTS; i++) begin
			tbl_status[i] = pte_pkg::ST_EMPTY; tbl_pid[i] = 0; tbl_wait[i] = 0;
			tbl_pend[i] = 0; tbl_ign[i] = 0;
		end
		pid_counter = 0; rr_pointer = 0; cfg_base = 0; cfg_stride = 32;
		repeat (7) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_directed();
		drain();
		test_pid_wrap();
		write_register(pte_pkg::CFG_TABLE_BASE, 16'hFFFF);
		write_register(pte_pkg::CFG_ENTRY_STRIDE, 16'd255);
		test_random(400, 30, 76);
		// hold off until every outstanding result is back
		drain();
		write_register(pte_pkg::CFG_TABLE_BASE, 16'h0000);
		write_register(pte_pkg::CFG_ENTRY_STRIDE, 16'd1);
		test_random(400, 76, 30);
		drain();
		write_register(pte_pkg::CFG_TABLE_BASE, 16'h1234);
		write_register(pte_pkg::CFG_ENTRY_STRIDE, 16'd32);
		test_random(400, 0, 0);
		drain();
		if (expected_q.size() != 0) errors++;
		$display("covered %0d requests, %0d results, three stall mixes, four register settings",
			requests_sent, results_seen);
		if (errors == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule

FILE: filelist.f
rtl/pte_pkg.sv
rtl/pte_if.sv
rtl/pte_ctrl.sv
rtl/pte_dp.sv
rtl/process_table_engine_unit.sv
sim/process_table_engine_unit_test.sv
